// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros; they expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdc_pkg
// Types, constants and the gain offset table of the ranging distance corrector.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int DIST_W = 24;
  localparam int FEI_W  = 24;
  localparam int REM_W  = 32;
  localparam int PH_W   = 35;
  localparam int FREQ_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SF   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ = 2'd2;

  localparam logic [3:0]        SF_RST   = 4'd7;
  localparam logic [3:0]        GAIN_RST = 4'd8;
  localparam logic [FREQ_W-1:0] FREQ_RST = 32'd2400000000;

  // shared divider geometry
  localparam int DIV_N_W   = 67;
  localparam int DIV_D_W   = 45;
  localparam int DIV_CNT_W = 7;

  localparam logic [DIV_CNT_W-1:0] SKEW_STEPS  = 7'd67;
  localparam logic [DIV_CNT_W-1:0] WAVE_STEPS  = 7'd45;
  localparam logic [DIV_CNT_W-1:0] MOD_STEPS   = 7'd31;
  localparam logic [DIV_CNT_W-1:0] PHASE_STEPS = 7'd48;

  // skew numerator is fei * 59041885 * 2^8; the 2^10 prescale of sf-5 is added
  localparam logic [25:0] SKEW_MUL  = 26'd59041885;
  localparam logic [9:0]  DEN_SCALE = 10'd1000;
  localparam logic [3:0]  SF_SHIFT_TOP = 4'd15;
  // speed of light times 2^16, wavelength numerator
  localparam logic [44:0] WAVE_NUM  = 45'd19641466880000;

  localparam logic [10:0] LNA_HIGH_OFS = 11'd1484;
  localparam logic [10:0] LNA_MID_OFS  = 11'd768;

  localparam logic [47:0] PH_NEG_LIM = 48'h4_0000_0000;
  localparam logic [47:0] PH_POS_LIM = 48'h3_FFFF_FFFF;

  typedef enum logic [1:0] {
    OP_SKEW,
    OP_WAVE,
    OP_MOD,
    OP_PHASE
  } div_op_t;

  typedef struct packed {
    logic    load_in;
    logic    div_start;
    logic    div_capture;
    logic    load_out;
    div_op_t op;
  } rdc_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic freq_zero;
    logic need_mod;
    logic out_free;
  } rdc_sts_t;

  // distance offset in 1/256 m for a receiver gain index
  function automatic logic [10:0] lna_offset(input logic [3:0] g);
    logic [10:0] ofs;
    case (g)
      4'd0: ofs = 11'd307;
      4'd1: ofs = 11'd256;
      4'd2: ofs = 11'd204;
      4'd3: ofs = 11'd153;
      4'd4: ofs = 11'd102;
      4'd5: ofs = 11'd51;
      4'd6: ofs = 11'd0;
      4'd7, 4'd8, 4'd9: ofs = LNA_MID_OFS;
      default: ofs = LNA_HIGH_OFS;
    endcase
    return ofs;
  endfunction

endpackage

// ===== src/rdc_ifs.sv =====
// ----------------------------------------------------------------------------
// rdc_ifs
// Valid/ready channel interfaces: input items, results and register writes.
// ----------------------------------------------------------------------------
interface rdc_in_if import rdc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DIST_W-1:0] raw_distance;
  logic signed [FEI_W-1:0]  fei_hz;

  modport source(output valid, raw_distance, fei_hz, input ready);
  modport sink(input valid, raw_distance, fei_hz, output ready);
endinterface

interface rdc_out_if import rdc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DIST_W-1:0] adj_distance;
  logic signed [REM_W-1:0]  remainder_distance;
  logic signed [PH_W-1:0]   phase;

  modport source(output valid, adj_distance, remainder_distance, phase, input ready);
  modport sink(input valid, adj_distance, remainder_distance, phase, output ready);
endinterface

interface rdc_cfg_if import rdc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== src/rdc_div.sv =====
// ----------------------------------------------------------------------------
// rdc_div
// Radix-2 restoring divider, one quotient bit per cycle, shared by all ops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdc_div import rdc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_N_W-1:0]   dividend,
  input  logic [DIV_D_W-1:0]   divisor,
  input  logic [DIV_CNT_W-1:0] steps,
  output logic                 busy,
  output logic                 done,
  output logic [DIV_N_W-1:0]   quotient,
  output logic [DIV_D_W-1:0]   remainder
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_N_W-1:0]   q_r, q_nxt;
  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_D_W-1:0]   dvs_r, dvs_nxt;
  logic [DIV_D_W:0]     partial;
  logic [DIV_D_W:0]     diff;
  logic                 fits;

  // dividend is left aligned; its bits shift out at the top as quotient
  // bits shift in at the bottom
  assign partial = {rem_r, q_r[DIV_N_W-1]};
  assign diff    = partial - {1'b0, dvs_r};
  assign fits    = !diff[DIV_D_W];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = steps;
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      q_nxt   = {q_r[DIV_N_W-2:0], fits};
      rem_nxt = fits ? diff[DIV_D_W-1:0] : partial[DIV_D_W-1:0];
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

  `ASSERT_IMPLIES(a_no_restart, start, !busy_r, "divider restarted while busy")

endmodule

// ===== src/rdc_dp.sv =====
// ----------------------------------------------------------------------------
// rdc_dp
// Datapath: config registers, operand staging, shared divider, output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdc_dp import rdc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic signed [DIST_W-1:0] in_raw_distance,
  input  logic signed [FEI_W-1:0]  in_fei_hz,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DIST_W-1:0] out_adj_distance,
  output logic signed [REM_W-1:0]  out_remainder_distance,
  output logic signed [PH_W-1:0]   out_phase,
  input  rdc_cmd_t                 cmd,
  output rdc_sts_t                 sts
);

  logic [3:0]        sf_r;
  logic [3:0]        gain_r;
  logic [FREQ_W-1:0] freq_r;
  logic [41:0]       den_r;
  logic [DIST_W-1:0] d_r;
  logic              neg_r;
  logic [FEI_W-1:0]  mf_r;
  logic [48:0]       prod_r;
  logic [24:0]       t_r;
  logic [REM_W-1:0]  rem_r;
  logic [44:0]       w_r;
  logic [PH_W-1:0]   ph_r;
  logic              out_valid_r;
  logic [DIST_W-1:0] out_corr_r;
  logic [REM_W-1:0]  out_rem_r;
  logic [PH_W-1:0]   out_ph_r;

  logic [DIV_N_W-1:0]   div_dvd;
  logic [DIV_D_W-1:0]   div_dvs;
  logic [DIV_CNT_W-1:0] div_steps;
  logic                 div_busy;
  logic                 div_done;
  logic [DIV_N_W-1:0]   div_q;
  logic [DIV_D_W-1:0]   div_rem;

  logic [REM_W-1:0]  rem_m1;
  logic [REM_W-1:0]  rem_mag;
  logic [3:0]        skew_sh;
  logic [57:0]       skew_q;
  logic [24:0]       skew_t;
  logic [47:0]       ph_q;
  logic [PH_W-1:0]   ph_mag;
  logic [PH_W-1:0]   ph_val;
  logic [26:0]       t_sgn;
  logic [26:0]       corr_sum;
  logic [DIST_W-1:0] corr_sat;
  logic              rem_le_w;
  logic              out_accept;

  assign rem_m1  = rem_r - 32'd1;
  assign rem_mag = rem_r[REM_W-1] ? (32'd0 - rem_r) : rem_r;
  assign rem_le_w = ({13'd0, rem_r} <= w_r);

  // operand select for the shared divider
  always_comb begin
    case (cmd.op)
      OP_SKEW: begin
        div_dvd   = {prod_r, 18'd0};
        div_dvs   = {3'd0, den_r};
        div_steps = SKEW_STEPS;
      end
      OP_WAVE: begin
        div_dvd   = {WAVE_NUM, 22'd0};
        div_dvs   = {13'd0, freq_r};
        div_steps = WAVE_STEPS;
      end
      OP_MOD: begin
        div_dvd   = {rem_m1[30:0], 36'd0};
        div_dvs   = w_r;
        div_steps = MOD_STEPS;
      end
      OP_PHASE: begin
        div_dvd   = {rem_mag, 35'd0};
        div_dvs   = w_r;
        div_steps = PHASE_STEPS;
      end
      default: begin
        div_dvd   = '0;
        div_dvs   = '0;
        div_steps = '0;
      end
    endcase
  end

  rdc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .steps     (div_steps),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // skew quotient carries 10 extra fraction bits; drop 15-sf of them
  assign skew_sh = SF_SHIFT_TOP - sf_r;
  assign skew_q  = div_q[57:0] >> skew_sh;
  assign skew_t  = (|skew_q[57:25]) ? '1 : skew_q[24:0];

  assign ph_q = div_q[47:0];
  always_comb begin
    if (rem_r[REM_W-1]) begin
      ph_mag = (ph_q > PH_NEG_LIM) ? PH_NEG_LIM[PH_W-1:0] : ph_q[PH_W-1:0];
      ph_val = '0 - ph_mag;
    end else begin
      ph_mag = (ph_q > PH_POS_LIM) ? PH_POS_LIM[PH_W-1:0] : ph_q[PH_W-1:0];
      ph_val = ph_mag;
    end
  end

  assign t_sgn    = neg_r ? (27'd0 - {2'd0, t_r}) : {2'd0, t_r};
  assign corr_sum = {{3{d_r[DIST_W-1]}}, d_r} + t_sgn - {16'd0, lna_offset(gain_r)};

  always_comb begin
    if (!corr_sum[26] && (|corr_sum[25:23])) begin
      corr_sat = 24'h7F_FFFF;
    end else if (corr_sum[26] && !(&corr_sum[25:23])) begin
      corr_sat = 24'h80_0000;
    end else begin
      corr_sat = corr_sum[23:0];
    end
  end

  assign out_accept = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_r        <= SF_RST;
      gain_r      <= GAIN_RST;
      freq_r      <= FREQ_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SF:   sf_r   <= cfg_data[3:0];
          CFG_GAIN: gain_r <= cfg_data[3:0];
          CFG_FREQ: freq_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_accept) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    den_r  <= {10'd0, freq_r} * {32'd0, DEN_SCALE};
    prod_r <= {25'd0, mf_r} * {23'd0, SKEW_MUL};
    if (cmd.load_in) begin
      d_r   <= in_raw_distance;
      neg_r <= in_fei_hz[FEI_W-1];
      mf_r  <= in_fei_hz[FEI_W-1] ? (24'd0 - in_fei_hz) : in_fei_hz;
      t_r   <= '0;
      rem_r <= {in_raw_distance, 8'd0};
      ph_r  <= '0;
    end
    if (cmd.div_capture) begin
      case (cmd.op)
        OP_SKEW:  t_r   <= skew_t;
        OP_WAVE:  w_r   <= div_q[44:0];
        OP_MOD:   rem_r <= {1'b0, div_rem[30:0]} + 32'd1;
        OP_PHASE: ph_r  <= ph_val;
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      out_corr_r <= corr_sat;
      out_rem_r  <= rem_r;
      out_ph_r   <= ph_r;
    end
  end

  assign sts.div_busy  = div_busy;
  assign sts.div_done  = div_done;
  assign sts.freq_zero = (freq_r == '0);
  assign sts.need_mod  = !rem_r[REM_W-1] && !rem_le_w;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid              = out_valid_r;
  assign out_adj_distance       = out_corr_r;
  assign out_remainder_distance = out_rem_r;
  assign out_phase              = out_ph_r;

  `ASSERT_IMPLIES(a_rem_reduced, cmd.load_out && !sts.freq_zero && !rem_r[REM_W-1],
                  rem_le_w, "remainder exceeds one wavelength")

endmodule

// ===== src/rdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rdc_ctrl
// Sequencer: runs the skew, wavelength, reduction (when needed) and phase divisions in turn.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdc_ctrl import rdc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rdc_sts_t sts,
  output rdc_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MOD_CHK,
    ST_FIN
  } state_t;

  state_t  state_r, state_nxt;
  div_op_t op_r, op_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    cmd.op    = op_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_PREP;
        end
      end
      ST_PREP: begin
        // skew product lands this cycle; zero frequency skips every division
        if (sts.freq_zero) begin
          state_nxt = ST_FIN;
        end else begin
          op_nxt    = OP_SKEW;
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.div_capture = 1'b1;
          case (op_r)
            OP_SKEW: begin
              op_nxt    = OP_WAVE;
              state_nxt = ST_DIV_GO;
            end
            OP_WAVE:  state_nxt = ST_MOD_CHK;
            OP_MOD: begin
              op_nxt    = OP_PHASE;
              state_nxt = ST_DIV_GO;
            end
            OP_PHASE: state_nxt = ST_FIN;
            default:  state_nxt = ST_FIN;
          endcase
        end
      end
      ST_MOD_CHK: begin
        op_nxt    = sts.need_mod ? OP_MOD : OP_PHASE;
        state_nxt = ST_DIV_GO;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_SKEW;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  `ASSERT_IMPLIES(a_done_in_wait, sts.div_done, state_r == ST_DIV_WAIT, "divider done outside wait")
  `ASSERT_NEXT(a_go_starts, state_r == ST_DIV_GO, sts.div_busy, "divider did not start")
  `ASSERT_IMPLIES(a_idle_quiet, state_r == ST_IDLE, !sts.div_busy, "divider busy while idle")

endmodule

// ===== src/ranging_distance_correction.sv =====
// A single radix-2 divider runs the skew, wavelength, reduction and phase divisions
// one after another; reduction runs only if the distance exceeds one wavelength,
// and a zero channel frequency skips every division. A new input item is taken
// only while idle, once the previous result is loaded into the output register.
// Reset: synchronous active low; registers return to sf 7, gain index 8, 2.4 GHz.
// ----------------------------------------------------------------------------
// ranging_distance_correction
// Skew and gain correction of a ranging distance, wavelength remainder, phase.
// ----------------------------------------------------------------------------
module ranging_distance_correction import rdc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rdc_in_if.sink    in_ch,
  rdc_out_if.source out_ch,
  rdc_cfg_if.sink   cfg_ch
);

  rdc_cmd_t cmd;
  rdc_sts_t sts;
  logic     cfg_ready;

  // register writes are always accepted
  assign cfg_ready    = 1'b1;
  assign cfg_ch.ready = cfg_ready;

  rdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rdc_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_valid              (cfg_ch.valid && cfg_ready),
    .cfg_index              (cfg_ch.index),
    .cfg_data               (cfg_ch.data),
    .in_raw_distance        (in_ch.raw_distance),
    .in_fei_hz              (in_ch.fei_hz),
    .out_valid              (out_ch.valid),
    .out_ready              (out_ch.ready),
    .out_adj_distance       (out_ch.adj_distance),
    .out_remainder_distance (out_ch.remainder_distance),
    .out_phase              (out_ch.phase),
    .cmd                    (cmd),
    .sts                    (sts)
  );

endmodule

// ===== verif/ranging_distance_correction_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ranging_distance_correction_tb
// Drives raw distance / frequency error transactions through the corrector
// under a series of register settings and random back-pressure, and checks
// every result against a bit-accurate fixed-point predictor kept in the bench.
// ----------------------------------------------------------------------------
module ranging_distance_correction_tb;
  import rdc_pkg::*;

  // spare register index, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // 197 us * 299705000 m/s * 2^8 (1/256 m), scaled by 1000
  localparam longint unsigned SKEW_SCALE  = 64'd15114722560;
  localparam longint unsigned WAVELEN_Q16 = 64'd19641466880000;
  localparam longint unsigned PH_NEG_SAT  = 64'd17179869184;
  localparam longint unsigned PH_POS_SAT  = 64'd17179869183;
  localparam int NUM_SETTINGS = 10;
  localparam int RANDOM_PER_SETTING = 160;

  typedef struct {
    logic signed [DIST_W-1:0] raw_d;
    logic signed [FEI_W-1:0]  fei;
  } range_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] corr;
    logic [REM_W-1:0]  rem;
    logic [PH_W-1:0]   ph;
  } range_result_t;

  logic clk;
  logic rst_n;

  rdc_in_if  in_ch ();
  rdc_out_if out_ch ();
  rdc_cfg_if cfg_ch ();

  ranging_distance_correction dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  range_item_t   raw_ranges[$];
  range_result_t range_results_due[$];

  logic [3:0]  sf_q   = 4'd7;
  logic [3:0]  gain_q = 4'd8;
  logic [31:0] freq_q = 32'd2400000000;

  int send_idle_pct    = 0;
  int result_stall_pct = 0;
  int ranges_issued    = 0;
  int results_checked  = 0;
  int mismatch_count   = 0;
  int settings_used    = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("FAIL ranging_distance_correction");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned skew_term(longint unsigned mf, logic [3:0] sf,
                                                logic [31:0] freq);
    longint unsigned num, den, q, r;
    num = mf * SKEW_SCALE;
    den = 64'(freq) * 64'd1000;
    if (freq == 0) return 0;
    if (sf >= 5) begin
      q = num / den;
      r = num % den;
      return (q << (sf - 5)) + ((r << (sf - 5)) / den);
    end
    return num / (den << (5 - sf));
  endfunction

  function automatic longint gain_offset(logic [3:0] g);
    if (g >= 10) return 1484;
    if (g >= 7) return 768;
    return (256 * (6 - g)) / 5;
  endfunction

  function automatic range_result_t correct_range(range_item_t it, logic [3:0] sf,
                                                  logic [3:0] g, logic [31:0] freq);
    longint d, fei, t, corr, rem, w, n, ph;
    longint unsigned mf, m;
    range_result_t res;
    d = it.raw_d;
    fei = it.fei;
    mf = (fei < 0) ? -fei : fei;
    t = skew_term(mf, sf, freq);
    corr = d + ((fei < 0) ? -t : t) - gain_offset(g);
    if (corr > 8388607) corr = 8388607;
    if (corr < -8388608) corr = -8388608;
    rem = d * 256;
    ph = 0;
    if (freq != 0) begin
      w = WAVELEN_Q16 / freq;
      // only positive distances are folded, into (0, w]
      if (rem > w) begin
        n = (rem - 1) / w;
        rem = rem - n * w;
      end
      m = (rem < 0) ? -rem : rem;
      m = m * 64'd65536 / w;
      if (rem < 0) ph = -$signed((m > PH_NEG_SAT) ? PH_NEG_SAT : m);
      else ph = $signed((m > PH_POS_SAT) ? PH_POS_SAT : m);
    end
    res.corr = corr[DIST_W-1:0];
    res.rem  = rem[REM_W-1:0];
    res.ph   = ph[PH_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic queue_range(logic [23:0] d, logic [23:0] f);
    range_item_t it;
    it.raw_d = d;
    it.fei = f;
    raw_ranges.push_back(it);
    ranges_issued++;
  endtask

  task automatic queue_random_range();
    logic [31:0] a, b;
    logic [23:0] corner[4];
    corner = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF};
    a = $urandom;
    b = $urandom;
    case ($urandom_range(3))
      0: queue_range(a[23:0], b[23:0]);
      1: queue_range(24'(a[10:0]) - 24'd1024, {{6{b[17]}}, b[17:0]});
      2: queue_range({7'd0, a[16:0]}, {{10{b[13]}}, b[13:0]});
      default: queue_range(corner[a[1:0]], corner[b[1:0]]);
    endcase
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic wait_drained();
    while (results_checked < ranges_issued) @(posedge clk);
  endtask

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 30) $display("%0t: mismatch: %s", $time, msg);
  endtask

  initial begin : run_plan
    logic [3:0]  sf, g;
    logic [31:0] f, junk;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.raw_distance = '0;
    in_ch.fei_hz = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_SF;
    cfg_ch.data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      if (p > 0) begin
        // registers change only with the pipe empty
        wait_drained();
        case (p)
          1: begin sf = 4'd0;  g = 4'd0;  f = 32'd2500000000; end
          2: begin sf = 4'd15; g = 4'd15; f = 32'hFFFF_FFFF;  end
          3: begin sf = 4'd12; g = 4'd13; f = 32'd0;          end
          4: begin sf = 4'd5;  g = 4'd6;  f = 32'd1;          end
          5: begin sf = 4'd4;  g = 4'd7;  f = 32'd2400000000; end
          6: begin sf = 4'd11; g = 4'd10; f = 32'd2450000000; end
          7: begin sf = 4'd9;  g = 4'd3;  f = 32'd1000;       end
          default: begin
            sf = 4'($urandom_range(15));
            g  = 4'($urandom_range(15));
            f  = 32'd2400000000 + $urandom_range(100000000);
          end
        endcase
        junk = $urandom;
        write_reg(CFG_SF, {junk[31:4], sf});
        write_reg(CFG_GAIN, {junk[27:0], g});
        write_reg(CFG_FREQ, f);
        if (p == 4) write_reg(CFG_SPARE, $urandom);
        cfg_ch.valid <= 1'b0;
      end

      case (p % 4)
        0: begin send_idle_pct = 0;  result_stall_pct = 0;  end
        1: begin send_idle_pct = 79; result_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  result_stall_pct = 79; end
        default: begin send_idle_pct = 10; result_stall_pct = 10; end
      endcase

      if (p == 0) begin
        queue_range(24'h000000, 24'h000000);
        queue_range(24'h7FFFFF, 24'h000000);
        queue_range(24'h800000, 24'h000000);
        queue_range(24'h000000, 24'h7FFFFF);
        queue_range(24'h000000, 24'h800000);
        queue_range(24'h7FFFFF, 24'h7FFFFF);
        queue_range(24'h800000, 24'h800000);
        queue_range(24'h7FFFFF, 24'h800000);
        queue_range(24'h800000, 24'h7FFFFF);
        queue_range(24'hFFFFFF, 24'hFFFFFF);
        queue_range(24'd1, 24'd1);
        // around one wavelength at 2.4 GHz (8183 in 1/65536 m)
        queue_range(24'd31, 24'd100);
        queue_range(24'd32, -24'sd100);
        queue_range(-24'sd32, 24'd5000);
        // exactly 256 wavelengths folds to a full turn
        queue_range(24'd8183, 24'd0);
        queue_range(24'd8184, 24'd0);
        queue_range(-24'sd8183, 24'd0);
        queue_range(24'hFFFFFF, 24'd1);
      end
      repeat (RANDOM_PER_SETTING) queue_random_range();
      settings_used++;
    end

    wait_drained();
    repeat (250) @(posedge clk);
    if (range_results_due.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", range_results_due.size()));
    $display("covered %0d ranging transactions over %0d register settings", ranges_issued,
             settings_used);
    $display("compared %0d results, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS ranging_distance_correction");
    end else begin
      $display("FAIL ranging_distance_correction");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : drive_ranges
    range_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (raw_ranges.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = raw_ranges.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.raw_distance <= nxt.raw_d;
        in_ch.fei_hz       <= nxt.fei;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= result_stall_pct);
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : watch_channels
    range_item_t   seen;
    range_result_t due;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_SF:   sf_q   = cfg_ch.data[3:0];
          CFG_GAIN: gain_q = cfg_ch.data[3:0];
          CFG_FREQ: freq_q = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.raw_d = in_ch.raw_distance;
        seen.fei   = in_ch.fei_hz;
        range_results_due.push_back(correct_range(seen, sf_q, gain_q, freq_q));
      end
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (range_results_due.size() == 0) begin
          flag_mismatch("result transaction with nothing expected");
        end else begin
          due = range_results_due.pop_front();
          if (out_ch.adj_distance !== due.corr)
            flag_mismatch($sformatf("adj_distance %h, want %h",
                                    $unsigned(out_ch.adj_distance), due.corr));
          if (out_ch.remainder_distance !== due.rem)
            flag_mismatch($sformatf("remainder_distance %h, want %h",
                                    $unsigned(out_ch.remainder_distance), due.rem));
          if (out_ch.phase !== due.ph)
            flag_mismatch($sformatf("phase %h, want %h", $unsigned(out_ch.phase), due.ph));
        end
      end
    end
  end

endmodule

// ===== files.f =====
+incdir+src
src/rdc_pkg.sv
src/rdc_ifs.sv
src/rdc_div.sv
src/rdc_dp.sv
src/rdc_ctrl.sv
src/ranging_distance_correction.sv
verif/ranging_distance_correction_tb.sv
